// ===== rtl/grff_pkg.sv =====
// ----------------------------------------------------------------------------
// grff_pkg
// Shared constants, types and helpers of the grid flood-fill block.
// ----------------------------------------------------------------------------
package grff_pkg;

    localparam int ROW_W        = 4;
    localparam int COL_W        = 5;
    localparam int MASK_W       = 32;
    localparam int CNT_W        = 6;
    localparam int ROWS_CFG_W   = 5;
    localparam int COLS_CFG_W   = 6;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 32;
    localparam int OUT_ROWS_CAP = 16;
    localparam int OUT_COLS_CAP = 32;

    localparam logic [ROWS_CFG_W-1:0] RST_ROWS = 5'd15;
    localparam logic [COLS_CFG_W-1:0] RST_COLS = 6'd22;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // register select is paddr[2]
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef struct packed {
        logic wr;          // blocked-flag write to the selected cell row
        logic wr_blocked;  // new flag value
        logic start;       // search accepted: seed / clear reach rows
        logic step;        // one wavefront step
        logic shift;       // move reach rows one row toward row 0
    } grff_ctl_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row_index;
        logic [MASK_W-1:0] reach_mask;
        logic              start_error;
        logic              last;
    } grff_res_t;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage

// ===== rtl/grff_in_if.sv =====
// ----------------------------------------------------------------------------
// grff_in_if
// Request channel: blocked-flag writes and search starts.
// ----------------------------------------------------------------------------
interface grff_in_if;
    import grff_pkg::*;

    logic             valid;
    logic             ready;
    logic             cmd;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             blocked;

    modport source (output valid, cmd, row, col, blocked, input ready);
    modport sink   (input valid, cmd, row, col, blocked, output ready);
endinterface

// ===== rtl/grff_out_if.sv =====
// ----------------------------------------------------------------------------
// grff_out_if
// Result channel: one reachable-cell mask per grid row.
// ----------------------------------------------------------------------------
interface grff_out_if;
    import grff_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  row_index;
    logic [MASK_W-1:0] reach_mask;
    logic [CNT_W-1:0]  row_count;
    logic              start_error;
    logic              last;

    modport source (output valid, row_index, reach_mask, row_count, start_error, last,
                    input ready);
    modport sink   (input valid, row_index, reach_mask, row_count, start_error, last,
                    output ready);
endinterface

// ===== rtl/grff_cell.sv =====
// ----------------------------------------------------------------------------
// grff_cell
// One grid row: blocked flags, reach flags and the local wavefront step.
// ----------------------------------------------------------------------------
module grff_cell #(
    parameter int COLS = grff_pkg::DEF_MAX_COLS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  grff_pkg::grff_ctl_t ctl,
    input  logic                sel,
    input  logic                active,
    input  logic [COLS-1:0]     col_hot,
    input  logic [COLS-1:0]     colmask,
    input  logic [COLS-1:0]     up,
    input  logic [COLS-1:0]     dn,
    output logic [COLS-1:0]     reach,
    output logic                changed
);
    import grff_pkg::*;

    logic [COLS-1:0] blocked_reg;
    logic [COLS-1:0] reach_reg;
    logic [COLS-1:0] grow;
    logic [COLS-1:0] reach_step;

    always_comb
    begin
        grow       = ((reach_reg << 1) | (reach_reg >> 1) | up | dn) & colmask & ~blocked_reg;
        reach_step = reach_reg | grow;
        changed    = active && (reach_step != reach_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocked_reg <= '0;
        end
        else if (ctl.wr && sel)
        begin
            if (ctl.wr_blocked)
            begin
                blocked_reg <= blocked_reg | col_hot;
            end
            else
            begin
                blocked_reg <= blocked_reg & ~col_hot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_reg <= '0;
        end
        else if (ctl.start)
        begin
            reach_reg <= sel ? col_hot : '0;
        end
        else if (ctl.step && active)
        begin
            reach_reg <= reach_step;
        end
        else if (ctl.shift)
        begin
            reach_reg <= dn;
        end
    end

    assign reach = reach_reg;

endmodule

// ===== rtl/grff_emit.sv =====
// ----------------------------------------------------------------------------
// grff_emit
// Result register: adds the row count and holds a result until taken.
// ----------------------------------------------------------------------------
module grff_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  grff_pkg::grff_res_t res,
    output logic                free,
    grff_out_if.source          rsp
);
    import grff_pkg::*;

    logic              valid_reg;
    grff_res_t         res_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        count_next = '0;
        for (int b = 0; b < MASK_W / 8; b++)
        begin
            count_next = count_next + CNT_W'(popcount8(res.reach_mask[b*8 +: 8]));
        end
    end

    assign free = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            res_reg   <= res;
            count_reg <= count_next;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.row_index   = res_reg.row_index;
    assign rsp.reach_mask  = res_reg.reach_mask;
    assign rsp.row_count   = count_reg;
    assign rsp.start_error = res_reg.start_error;
    assign rsp.last        = res_reg.last;

endmodule

// ===== rtl/grid_reachability_flood_fill_top.sv =====
// ----------------------------------------------------------------------------
// grid_reachability_flood_fill_top
// 4-connected flood fill over a grid of blocked-cell flags.
// ----------------------------------------------------------------------------
// Usage:
//   req  : write transactions (cmd=0) set or clear one blocked flag; search
//          transactions (cmd=1) give the start cell.
//   rsp  : one transaction per row in use, row 0 first, last on the final one.
//          A start outside the rows/columns in use gives one transaction with
//          start_error and last set.
//   APB  : rows_in_use at 0x0, cols_in_use at 0x4; write only while idle.
// Timing:
//   A write updates one blocked flag as it is taken. A search seeds the
//   start cell, then steps the wavefront once per step of the longest
//   shortest path from the start plus one quiet step, then drains one row
//   at a time through the result register. The row cells step in parallel,
//   so the maze path length sets the search time.
//   req is taken only between searches; a finished result may still sit in
//   the result register while the next transaction is taken.
// Reset clears all blocked flags and reach flags and loads rows_in_use=15,
// cols_in_use=22. A stalled receiver holds the result and pauses the drain.
// ----------------------------------------------------------------------------
module grid_reachability_flood_fill_top #(
    parameter int MAX_ROWS = grff_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = grff_pkg::DEF_MAX_COLS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    grff_in_if.sink                       req,
    grff_out_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [grff_pkg::APB_AW-1:0]   paddr,
    input  logic [grff_pkg::APB_DW-1:0]   pwdata,
    output logic [grff_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import grff_pkg::*;

    localparam int ROW_CAP = (MAX_ROWS < OUT_ROWS_CAP) ? MAX_ROWS : OUT_ROWS_CAP;
    localparam int COL_CAP = (MAX_COLS < OUT_COLS_CAP) ? MAX_COLS : OUT_COLS_CAP;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FLOOD = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;
    localparam logic [1:0] ST_ERR   = 2'd3;

    // configuration
    logic [ROWS_CFG_W-1:0] rows_cfg_reg;
    logic [COLS_CFG_W-1:0] cols_cfg_reg;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= RST_ROWS;
            cols_cfg_reg <= RST_COLS;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ROWS: rows_cfg_reg <= pwdata[ROWS_CFG_W-1:0];
                REG_COLS: cols_cfg_reg <= pwdata[COLS_CFG_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ROWS: prdata = APB_DW'(rows_cfg_reg);
            REG_COLS: prdata = APB_DW'(cols_cfg_reg);
            default:  prdata = '0;
        endcase
    end

    // control state
    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [ROW_W-1:0]      emit_idx_reg;
    logic [ROW_W-1:0]      emit_idx_next;
    logic [MAX_COLS-1:0]   colmask_reg;
    logic [MAX_COLS-1:0]   colmask_next;

    logic                  accept;
    logic                  start_ok;
    logic [ROWS_CFG_W-1:0] rows_eff;
    logic [COLS_CFG_W-1:0] cols_eff;
    logic                  emit_last;
    logic                  emit_free;
    logic                  emit_load;
    logic                  any_changed;
    grff_ctl_t             ctl;
    grff_res_t             res;

    logic [MAX_COLS-1:0]   col_hot;
    logic [MAX_ROWS-1:0]   row_sel;
    logic [MAX_ROWS-1:0]   row_active;
    logic [MAX_ROWS-1:0]   changed_vec;
    logic [MAX_COLS-1:0]   reach_w [MAX_ROWS];
    logic [MASK_W-1:0]     head_mask;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        rows_eff = (32'(rows_cfg_reg) > ROW_CAP) ? ROWS_CFG_W'(ROW_CAP) : rows_cfg_reg;
        cols_eff = (32'(cols_cfg_reg) > COL_CAP) ? COLS_CFG_W'(COL_CAP) : cols_cfg_reg;
        start_ok = (ROWS_CFG_W'(req.row) < rows_eff) && (COLS_CFG_W'(req.col) < cols_eff);
        for (int c = 0; c < MAX_COLS; c++)
        begin
            colmask_next[c] = (c < 32'(cols_eff));
        end
    end

    genvar gc;
    genvar gr;
    generate
        for (gc = 0; gc < MAX_COLS; gc++)
        begin : g_col
            // seed bit only for a valid start; writes use the plain decode
            assign col_hot[gc] = (32'(req.col) == gc) && (req.cmd == CMD_WRITE || start_ok);
        end
        for (gc = 0; gc < MASK_W; gc++)
        begin : g_head
            if (gc < MAX_COLS)
            begin : g_in
                assign head_mask[gc] = reach_w[0][gc];
            end
            else
            begin : g_pad
                assign head_mask[gc] = 1'b0;
            end
        end
    endgenerate

    assign emit_last = ({1'b0, emit_idx_reg} == rows_reg - ROWS_CFG_W'(1));
    assign emit_load = (state_reg == ST_EMIT) || (state_reg == ST_ERR);
    assign any_changed = |changed_vec;

    always_comb
    begin
        ctl.wr         = accept && (req.cmd == CMD_WRITE);
        ctl.wr_blocked = req.blocked;
        ctl.start      = accept && (req.cmd == CMD_SEARCH);
        ctl.step       = (state_reg == ST_FLOOD);
        ctl.shift      = (state_reg == ST_EMIT) && emit_free;
    end

    always_comb
    begin
        if (state_reg == ST_ERR)
        begin
            res.row_index   = '0;
            res.reach_mask  = '0;
            res.start_error = 1'b1;
            res.last        = 1'b1;
        end
        else
        begin
            res.row_index   = emit_idx_reg;
            res.reach_mask  = head_mask;
            res.start_error = 1'b0;
            res.last        = emit_last;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        emit_idx_next = emit_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = start_ok ? ST_FLOOD : ST_ERR;
                end
            end
            ST_FLOOD:
            begin
                if (!any_changed)
                begin
                    state_next    = ST_EMIT;
                    emit_idx_next = '0;
                end
            end
            ST_EMIT:
            begin
                if (emit_free)
                begin
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + ROW_W'(1);
                    end
                end
            end
            ST_ERR:
            begin
                if (emit_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            emit_idx_reg <= '0;
            rows_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            emit_idx_reg <= emit_idx_next;
            if (ctl.start)
            begin
                rows_reg <= rows_eff;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            colmask_reg <= colmask_next;
        end
    end

    // row cells
    generate
        for (gr = 0; gr < MAX_ROWS; gr++)
        begin : g_row
            logic [MAX_COLS-1:0] up_w;
            logic [MAX_COLS-1:0] dn_w;

            assign row_sel[gr]    = (32'(req.row) == gr);
            assign row_active[gr] = (gr < 32'(rows_reg));

            if (gr == 0)
            begin : g_top
                assign up_w = '0;
            end
            else
            begin : g_up
                assign up_w = reach_w[gr-1];
            end

            if (gr == MAX_ROWS - 1)
            begin : g_bot
                assign dn_w = '0;
            end
            else
            begin : g_dn
                assign dn_w = reach_w[gr+1];
            end

            grff_cell #(
                .COLS (MAX_COLS)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .sel     (row_sel[gr]),
                .active  (row_active[gr]),
                .col_hot (col_hot),
                .colmask (colmask_reg),
                .up      (up_w),
                .dn      (dn_w),
                .reach   (reach_w[gr]),
                .changed (changed_vec[gr])
            );
        end
    endgenerate

    grff_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (emit_load),
        .res   (res),
        .free  (emit_free),
        .rsp   (rsp)
    );

`ifndef SYNTH
    a_flood_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLOOD && any_changed) |=> (state_reg == ST_FLOOD))
        else $error("flood ended while the wavefront still grew");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ({1'b0, emit_idx_reg} < rows_reg))
        else $error("row drain index beyond rows in use");

    a_bad_start: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.start && !start_ok) |=> (state_reg == ST_ERR))
        else $error("start outside grid not routed to error result");

    a_no_step_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_FLOOD) |-> !ctl.step)
        else $error("wavefront step outside flood phase");

    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.start_error) |-> (rsp.last && rsp.reach_mask == '0))
        else $error("error result carries reach data or lacks last");
`endif

endmodule

// ===== bench/grid_reachability_flood_fill_top_test.sv =====
// ----------------------------------------------------------------------------
// grid_reachability_flood_fill_top_test
// Self-checking bench for the 4-connected grid flood-fill block. Cell writes
// and searches go in on the request channel in random bursts. A scoreboard
// keeps its own blocked map and grid size and floods from each start. Every
// row mask that comes back is compared field by field with the oldest
// expected row. The grid size is changed over APB between phases, including
// zero and out-of-range sizes, a long snaking maze and a long receiver stall.
// ----------------------------------------------------------------------------
module grid_reachability_flood_fill_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import grff_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 400;

    localparam logic [APB_AW-1:0] ADDR_ROWS = {REG_ROWS, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_COLS = {REG_COLS, 2'b00};

    typedef struct packed {
        logic             cmd;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             blocked;
    } grid_request_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row_index;
        logic [MASK_W-1:0] reach_mask;
        logic [CNT_W-1:0]  row_count;
        logic              start_error;
        logic              last;
    } row_mask_t;

    typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

    class reach_scoreboard;
        logic [MASK_W-1:0]     blocked_rows [OUT_ROWS_CAP];
        logic [ROWS_CFG_W-1:0] rows_cfg;
        logic [COLS_CFG_W-1:0] cols_cfg;
        row_mask_t             pending_rows [$];
        int                    errors;
        int                    cell_writes;
        int                    searches;
        int                    off_grid_searches;
        int                    rows_checked;

        function new();
            foreach (blocked_rows[r])
                blocked_rows[r] = '0;
            rows_cfg = RST_ROWS;
            cols_cfg = RST_COLS;
        endfunction

        // Update the blocked map, or flood from the start cell and queue one
        // mask per row in use.
        function void note_request(grid_request_t it);
            logic [MASK_W-1:0] reach [OUT_ROWS_CAP];
            logic [MASK_W-1:0] colmask;
            logic [MASK_W-1:0] grow;
            row_mask_t         res;
            int unsigned       nrows;
            int unsigned       ncols;
            bit                changed;
            if (it.cmd == CMD_WRITE)
            begin
                blocked_rows[it.row][it.col] = it.blocked;
                cell_writes++;
                return;
            end
            searches++;
            nrows = (rows_cfg > OUT_ROWS_CAP) ? OUT_ROWS_CAP : rows_cfg;
            ncols = (cols_cfg > OUT_COLS_CAP) ? OUT_COLS_CAP : cols_cfg;
            if (it.row >= nrows || it.col >= ncols)
            begin
                off_grid_searches++;
                res = '0;
                res.start_error = 1'b1;
                res.last = 1'b1;
                pending_rows = {pending_rows, res};
                return;
            end
            colmask = (ncols == MASK_W) ? '1 : ((MASK_W'(1) << ncols) - MASK_W'(1));
            for (int r = 0; r < OUT_ROWS_CAP; r++)
                reach[r] = '0;
            // start is marked even when it is blocked
            reach[it.row][it.col] = 1'b1;
            do
            begin
                changed = 1'b0;
                for (int r = 0; r < nrows; r++)
                begin
                    grow = (reach[r] << 1) | (reach[r] >> 1);
                    if (r > 0)
                        grow |= reach[r-1];
                    if (r + 1 < nrows)
                        grow |= reach[r+1];
                    grow &= colmask & ~blocked_rows[r];
                    if ((grow | reach[r]) != reach[r])
                    begin
                        reach[r] |= grow;
                        changed = 1'b1;
                    end
                end
            end
            while (changed);
            for (int r = 0; r < nrows; r++)
            begin
                res.row_index   = ROW_W'(r);
                res.reach_mask  = reach[r] & colmask;
                res.row_count   = CNT_W'($countones(reach[r] & colmask));
                res.start_error = 1'b0;
                res.last        = (r + 1 == nrows);
                pending_rows = {pending_rows, res};
            end
        endfunction

        function void report_field(string name, logic [MASK_W-1:0] want,
                                   logic [MASK_W-1:0] got);
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        endfunction

        function void check_row_mask(row_mask_t got);
            row_mask_t want;
            if (pending_rows.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected row mask, expected none, actual row %0d mask %h",
                         $time, got.row_index, got.reach_mask);
                return;
            end
            want = pending_rows.pop_front();
            rows_checked++;
            if (got.row_index !== want.row_index)
                report_field("row_index", MASK_W'(want.row_index), MASK_W'(got.row_index));
            if (got.reach_mask !== want.reach_mask)
                report_field("reach_mask", want.reach_mask, got.reach_mask);
            if (got.row_count !== want.row_count)
                report_field("row_count", MASK_W'(want.row_count), MASK_W'(got.row_count));
            if (got.start_error !== want.start_error)
                report_field("start_error", MASK_W'(want.start_error),
                             MASK_W'(got.start_error));
            if (got.last !== want.last)
                report_field("last", MASK_W'(want.last), MASK_W'(got.last));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    grff_in_if  req_if ();
    grff_out_if rsp_if ();

    grid_reachability_flood_fill_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    reach_scoreboard sb;
    int              cycle_count = 0;
    int              burst_left = 0;
    bit              sender_gaps = 1'b1;
    int              hold_request = 0;
    int              grid_sizes = 1;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d rows outstanding",
                     cycle_count, sb.pending_rows.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: checks each transaction, stalls on its own modes.
    initial
    begin
        rx_mode_t   rx_mode;
        int         mode_left;
        int         hold_left;
        logic [7:0] stall_bits;
        row_mask_t  got;
        rx_mode    = RX_ALWAYS;
        mode_left  = 0;
        hold_left  = 0;
        stall_bits = 8'hff;
        rsp_if.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.row_index   = rsp_if.row_index;
                got.reach_mask  = rsp_if.reach_mask;
                got.row_count   = rsp_if.row_count;
                got.start_error = rsp_if.start_error;
                got.last        = rsp_if.last;
                sb.check_row_mask(got);
            end
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                rx_mode    = rx_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(40, 160);
                stall_bits = 8'($urandom) | 8'h01;
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS:  rsp_if.ready <= 1'b1;
                    RX_COIN:    rsp_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:  rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        rsp_if.ready <= stall_bits[0];
                        stall_bits = {stall_bits[0], stall_bits[7:1]};
                    end
                endcase
            end
        end
    end

    function automatic grid_request_t mk_write(int r, int c, bit b);
        grid_request_t it;
        it.cmd     = CMD_WRITE;
        it.row     = ROW_W'(r);
        it.col     = COL_W'(c);
        it.blocked = b;
        return it;
    endfunction

    function automatic grid_request_t mk_search(int r, int c);
        grid_request_t it;
        it.cmd     = CMD_SEARCH;
        it.row     = ROW_W'(r);
        it.col     = COL_W'(c);
        it.blocked = 1'($urandom);
        return it;
    endfunction

    // Mostly cells inside the grid in use; the rest anywhere in storage.
    function automatic grid_request_t random_request();
        grid_request_t it;
        int unsigned   nrows;
        int unsigned   ncols;
        nrows      = (sb.rows_cfg > OUT_ROWS_CAP) ? OUT_ROWS_CAP : sb.rows_cfg;
        ncols      = (sb.cols_cfg > OUT_COLS_CAP) ? OUT_COLS_CAP : sb.cols_cfg;
        it.cmd     = ($urandom_range(0, 99) < 25) ? CMD_SEARCH : CMD_WRITE;
        it.blocked = ($urandom_range(0, 99) < 40);
        if (nrows > 0 && ncols > 0 && $urandom_range(0, 99) < 85)
        begin
            it.row = ROW_W'($urandom_range(0, nrows - 1));
            it.col = COL_W'($urandom_range(0, ncols - 1));
        end
        else
        begin
            it.row = ROW_W'($urandom);
            it.col = COL_W'($urandom);
        end
        return it;
    endfunction

    task automatic send_request(input grid_request_t it);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap != 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_if.valid   <= 1'b1;
        req_if.cmd     <= it.cmd;
        req_if.row     <= it.row;
        req_if.col     <= it.col;
        req_if.blocked <= it.blocked;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_request(it);
        burst_left--;
    endtask

    // Setup and access phases, then idle with psel low so writes never overlap.
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        while (sb.pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Upper data bits are junk on purpose; only the register width counts.
    task automatic configure_grid(input int rows_val, input int cols_val);
        settle();
        write_reg(ADDR_ROWS, ($urandom & ~32'h1f) | APB_DW'(rows_val & 32'h1f));
        sb.rows_cfg = ROWS_CFG_W'(rows_val);
        write_reg(ADDR_COLS, ($urandom & ~32'h3f) | APB_DW'(cols_val & 32'h3f));
        sb.cols_cfg = COLS_CFG_W'(cols_val);
        grid_sizes++;
    endtask

    task automatic random_phase(input int rows_val, input int cols_val, input int count,
                                input bit gaps);
        configure_grid(rows_val, cols_val);
        sender_gaps = gaps;
        repeat (count) send_request(random_request());
    endtask

    initial
    begin
        sb = new();
        req_if.valid   <= 1'b0;
        req_if.cmd     <= CMD_WRITE;
        req_if.row     <= '0;
        req_if.col     <= '0;
        req_if.blocked <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, on the reset grid size
        send_request(mk_search(0, 0));
        send_request(mk_write(0, 0, 1'b1));
        send_request(mk_search(0, 0));          // blocked start
        send_request(mk_write(1, 0, 1'b1));
        send_request(mk_write(0, 1, 1'b1));
        send_request(mk_search(0, 0));          // sealed corner: start only
        send_request(mk_search(2, 2));
        send_request(mk_write(15, 31, 1'b1));   // stored, outside the grid in use
        send_request(mk_write(3, 25, 1'b1));
        send_request(mk_search(14, 21));
        send_request(mk_write(14, 20, 1'b1));
        send_request(mk_write(13, 21, 1'b1));
        send_request(mk_search(14, 21));
        send_request(mk_search(15, 0));         // start off grid
        send_request(mk_search(0, 22));
        send_request(mk_search(15, 31));
        send_request(mk_write(0, 0, 1'b0));
        send_request(mk_write(1, 0, 1'b0));
        send_request(mk_write(0, 1, 1'b0));

        random_phase(16, 32, 55, 1'b1);
        random_phase(1, 1, 20, 1'b0);
        random_phase(1, 32, 25, 1'b0);
        random_phase(16, 1, 25, 1'b1);
        random_phase(0, 7, 10, 1'b1);
        random_phase(9, 0, 10, 1'b1);

        // out-of-range sizes clamp; receiver stalls long so the block backs up
        configure_grid(31, 63);
        sender_gaps = 1'b0;
        hold_request = LONG_HOLD;
        repeat (40) send_request(random_request());

        // snaking maze: walls on odd rows with the opening at alternate ends
        configure_grid(6, 8);
        sender_gaps = 1'b1;
        for (int r = 0; r < 6; r++)
        begin
            for (int c = 0; c < 8; c++)
                send_request(mk_write(r, c, r[0] && (c != (r[1] ? 0 : 7))));
        end
        send_request(mk_search(0, 0));
        send_request(mk_search(5, 0));
        repeat (10) send_request(random_request());

        random_phase($urandom_range(1, 16), $urandom_range(1, 32), 35, 1'b1);
        random_phase($urandom_range(1, 16), $urandom_range(1, 32), 35, 1'b1);

        settle();
        $display("Covered %0d cell writes and %0d searches (%0d off grid) over %0d grid sizes.",
                 sb.cell_writes, sb.searches, sb.off_grid_searches, grid_sizes);
        $display("Checked %0d row masks in %0d cycles.", sb.rows_checked, cycle_count);
        if (sb.errors == 0 && sb.pending_rows.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/grff_pkg.sv
rtl/grff_in_if.sv
rtl/grff_out_if.sv
rtl/grff_cell.sv
rtl/grff_emit.sv
rtl/grid_reachability_flood_fill_top.sv
bench/grid_reachability_flood_fill_top_test.sv
